@@ rtl/gtg_pkg.sv @@
// Shared types, constants and the CORDIC arctangent table for the go-to-goal controller.
package gtg_pkg;

    localparam int POS_W       = 16;
    localparam int HD_W        = 15;
    localparam int CMD_W       = 18;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int DELTA_W     = POS_W + 1;
    localparam int GUARD       = 16;
    localparam int XW          = DELTA_W + GUARD + 3;
    localparam int ZW          = 34;
    localparam int ATAN_LEN    = 24;
    localparam int GAIN_W      = 30;
    localparam int XU_W        = 34;
    localparam int XH_W        = XU_W / 2;
    localparam int MUL_W       = XH_W + GAIN_W;
    localparam int SUM_W       = 64;
    localparam int DIST_SH     = GAIN_W + GUARD;
    localparam int DIST_W      = 18;
    localparam int BEAR_W      = 20;
    localparam int ANG_W       = 24;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [ZW-1:0]      PI_Q30      = 34'd3373259426;
    localparam logic [ZW-1:0]      HALF_PI_Q30 = 34'd1686629713;
    localparam logic [GAIN_W-1:0]  INV_GAIN    = 30'd652032874;
    localparam logic [CFG_W-1:0]   TOL_RESET   = 16'd41;
    localparam logic [CMD_W-1:0]   LIN_MAX     = 18'h3FFFF;
    localparam int                 ANG_LIM18   = 131071;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GOAL_X   = 2'd0,
        REG_GOAL_Y   = 2'd1,
        REG_STOP_TOL = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        QUAD_NONE = 2'd0,
        QUAD_POS  = 2'd1,
        QUAD_NEG  = 2'd2
    } quad_t;

    typedef struct packed {
        logic signed [DELTA_W-1:0] x0;
        logic signed [DELTA_W-1:0] y0;
        quad_t                     quad;
        logic signed [HD_W-1:0]    heading;
    } pose_item_t;

    function automatic logic signed [ZW-1:0] atan_q30(input int unsigned idx);
        logic signed [ZW-1:0] v;
        case (idx)
            0:       v = ZW'(843314857);
            1:       v = ZW'(497837829);
            2:       v = ZW'(263043837);
            3:       v = ZW'(133525159);
            4:       v = ZW'(67021687);
            5:       v = ZW'(33543516);
            6:       v = ZW'(16775851);
            7:       v = ZW'(8388437);
            8:       v = ZW'(4194283);
            9:       v = ZW'(2097149);
            10:      v = ZW'(1048576);
            11:      v = ZW'(524288);
            12:      v = ZW'(262144);
            13:      v = ZW'(131072);
            14:      v = ZW'(65536);
            15:      v = ZW'(32768);
            16:      v = ZW'(16384);
            17:      v = ZW'(8192);
            18:      v = ZW'(4096);
            19:      v = ZW'(2048);
            20:      v = ZW'(1024);
            21:      v = ZW'(512);
            22:      v = ZW'(256);
            23:      v = ZW'(128);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/gtg_pose_if.sv @@
// Pose input channel: valid/ready handshake with position and heading payload.
interface gtg_pose_if;
    import gtg_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [POS_W-1:0]       pos_x;
    logic [POS_W-1:0]       pos_y;
    logic signed [HD_W-1:0] heading;

    modport source (output valid, output pos_x, output pos_y, output heading, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input heading, output ready);
endinterface

@@ rtl/gtg_cmd_if.sv @@
// Drive command channel: valid/ready handshake with speed, turn rate and reached flag.
interface gtg_cmd_if;
    import gtg_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        lin_cmd;
    logic signed [CMD_W-1:0] ang_cmd;
    logic                    reached;

    modport source (output valid, output lin_cmd, output ang_cmd, output reached, input ready);
    modport sink   (input valid, input lin_cmd, input ang_cmd, input reached, output ready);
endinterface

@@ rtl/gtg_front.sv @@
// Front end: takes pose transfers, forms goal deltas and the quadrant pre-rotation.
module gtg_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [gtg_pkg::CFG_W-1:0] goal_x,
    input  logic [gtg_pkg::CFG_W-1:0] goal_y,
    gtg_pose_if.sink                  pose,
    output logic                      item_valid,
    output gtg_pkg::pose_item_t       item,
    input  logic                      item_ready
);
    import gtg_pkg::*;

    logic                      valid_reg;
    pose_item_t                item_reg;
    pose_item_t                item_next;
    logic                      take;
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;

    assign take       = !valid_reg || item_ready;
    assign pose.ready = take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    assign dx = $signed({1'b0, goal_x}) - $signed({1'b0, pose.pos_x});
    assign dy = $signed({1'b0, goal_y}) - $signed({1'b0, pose.pos_y});

    // rotate left-half vectors by +-90 degrees so the iterations converge
    always_comb
    begin
        item_next.heading = pose.heading;
        if (dx < 0)
        begin
            if (dy >= 0)
            begin
                item_next.x0   = dy;
                item_next.y0   = -dx;
                item_next.quad = QUAD_POS;
            end
            else
            begin
                item_next.x0   = -dy;
                item_next.y0   = dx;
                item_next.quad = QUAD_NEG;
            end
        end
        else
        begin
            item_next.x0   = dx;
            item_next.y0   = dy;
            item_next.quad = QUAD_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= pose.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && pose.valid)
        begin
            item_reg <= item_next;
        end
    end
endmodule

@@ rtl/gtg_queue.sv @@
// Short queue between the front end and the CORDIC back end.
module gtg_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_valid,
    input  gtg_pkg::pose_item_t wr_item,
    output logic                wr_ready,
    output logic                rd_valid,
    output gtg_pkg::pose_item_t rd_item,
    input  logic                rd_ready
);
    import gtg_pkg::*;

    pose_item_t        mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              push;
    logic              pop;

    assign wr_ready = (count_reg != (QPTR_W + 1)'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_item  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end
endmodule

@@ rtl/gtg_back.sv @@
// Back end: pipelined vectoring CORDIC, gain correction, command forming and output register.
module gtg_back #(
    parameter int FRAC_BITS     = 12,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [gtg_pkg::CFG_W-1:0] stop_tolerance,
    input  logic                      item_valid,
    input  gtg_pkg::pose_item_t       item,
    output logic                      item_ready,
    gtg_cmd_if.source                 cmd
);
    import gtg_pkg::*;

    localparam int NS = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;
    localparam int SH = 30 - FRAC_BITS;
    localparam logic [ZW-1:0] RND = ZW'(1) << (SH - 1);
    localparam logic [ZW-1:0] PI_F = (PI_Q30 + RND) >> SH;
    localparam logic signed [ZW:0] PI_Z = signed'((ZW + 1)'(PI_F));
    localparam logic signed [BEAR_W-1:0] PI_B = signed'(BEAR_W'(PI_F));
    localparam int LIM8 = 8 * int'(PI_F);
    localparam int LIM = (LIM8 > ANG_LIM18) ? ANG_LIM18 : LIM8;
    localparam logic signed [ANG_W-1:0] ANG_LIM = signed'(ANG_W'(LIM));

    logic en;

    // CORDIC pipeline registers
    logic signed [XW-1:0]   x_reg [NS];
    logic signed [XW-1:0]   y_reg [NS];
    logic signed [ZW-1:0]   z_reg [NS];
    logic signed [HD_W-1:0] h_reg [NS];
    logic                   v_reg [NS];

    logic signed [XW-1:0] x_init;
    logic signed [XW-1:0] y_init;
    logic signed [ZW-1:0] z_init;

    // multiply stage
    logic [XU_W-1:0]        xc;
    logic [MUL_W-1:0]       m_lo_reg;
    logic [MUL_W-1:0]       m_hi_reg;
    logic signed [ZW-1:0]   m_z_reg;
    logic signed [HD_W-1:0] m_hd_reg;
    logic                   m_v_reg;

    // distance and bearing stage
    logic [SUM_W-1:0]         sum;
    logic signed [ZW:0]       z_rnd;
    logic signed [ZW:0]       bear_full;
    logic [DIST_W-1:0]        dist_next;
    logic signed [BEAR_W-1:0] bear_next;
    logic [DIST_W-1:0]        d_dist_reg;
    logic signed [BEAR_W-1:0] d_bear_reg;
    logic signed [HD_W-1:0]   d_hd_reg;
    logic                     d_v_reg;

    // output stage
    logic [DIST_W+1:0]        lin_full;
    logic signed [ANG_W-1:0]  ang_full;
    logic                     reached_next;
    logic [CMD_W-1:0]         lin_next;
    logic signed [CMD_W-1:0]  ang_next;
    logic                     out_valid_reg;
    logic [CMD_W-1:0]         lin_reg;
    logic signed [CMD_W-1:0]  ang_reg;
    logic                     reached_reg;

    assign en         = !out_valid_reg || cmd.ready;
    assign item_ready = en;

    assign x_init = XW'(item.x0) <<< GUARD;
    assign y_init = XW'(item.y0) <<< GUARD;

    always_comb
    begin
        case (item.quad)
            QUAD_POS: z_init = signed'(HALF_PI_Q30);
            QUAD_NEG: z_init = -signed'(HALF_PI_Q30);
            default:  z_init = '0;
        endcase
    end

    for (genvar i = 0; i < NS; i++)
    begin : g_stage
        logic signed [XW-1:0]   xi;
        logic signed [XW-1:0]   yi;
        logic signed [ZW-1:0]   zi;
        logic signed [HD_W-1:0] hi;
        logic                   vi;
        logic signed [XW-1:0]   x_next;
        logic signed [XW-1:0]   y_next;
        logic signed [ZW-1:0]   z_next;

        if (i == 0)
        begin : g_first
            assign xi = x_init;
            assign yi = y_init;
            assign zi = z_init;
            assign hi = item.heading;
            assign vi = item_valid;
        end
        else
        begin : g_rest
            assign xi = x_reg[i-1];
            assign yi = y_reg[i-1];
            assign zi = z_reg[i-1];
            assign hi = h_reg[i-1];
            assign vi = v_reg[i-1];
        end

        always_comb
        begin
            if (yi > 0)
            begin
                x_next = xi + (yi >>> i);
                y_next = yi - (xi >>> i);
                z_next = zi + atan_q30(i);
            end
            else
            begin
                x_next = xi - (yi >>> i);
                y_next = yi + (xi >>> i);
                z_next = zi - atan_q30(i);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[i] <= vi;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i] <= x_next;
                y_reg[i] <= y_next;
                z_reg[i] <= z_next;
                h_reg[i] <= hi;
            end
        end
    end

    // gain correction split into two 17x30 products
    assign xc = (x_reg[NS-1] < 0) ? '0 : XU_W'(x_reg[NS-1]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_lo_reg <= MUL_W'(xc[XH_W-1:0]) * MUL_W'(INV_GAIN);
            m_hi_reg <= MUL_W'(xc[XU_W-1:XH_W]) * MUL_W'(INV_GAIN);
            m_z_reg  <= z_reg[NS-1];
            m_hd_reg <= h_reg[NS-1];
        end
    end

    assign sum       = (SUM_W'(m_hi_reg) << XH_W) + SUM_W'(m_lo_reg)
                       + (SUM_W'(1) << (DIST_SH - 1));
    assign dist_next = sum[DIST_SH +: DIST_W];
    assign z_rnd     = (ZW + 1)'(m_z_reg) + signed'((ZW + 1)'(RND));
    assign bear_full = z_rnd >>> SH;

    always_comb
    begin
        if (bear_full > PI_Z)
        begin
            bear_next = PI_B;
        end
        else if (bear_full < -PI_Z)
        begin
            bear_next = -PI_B;
        end
        else
        begin
            bear_next = BEAR_W'(bear_full);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_dist_reg <= dist_next;
            d_bear_reg <= bear_next;
            d_hd_reg   <= m_hd_reg;
        end
    end

    assign reached_next = (d_dist_reg <= DIST_W'(stop_tolerance));
    assign lin_full     = ((DIST_W + 2)'(d_dist_reg) * (DIST_W + 2)'(3)
                          + (DIST_W + 2)'(1)) >> 1;
    assign ang_full     = (ANG_W'(d_bear_reg) - ANG_W'(d_hd_reg)) <<< 2;

    always_comb
    begin
        if (reached_next)
        begin
            lin_next = '0;
            ang_next = '0;
        end
        else
        begin
            lin_next = (lin_full > (DIST_W + 2)'(LIN_MAX)) ? LIN_MAX : CMD_W'(lin_full);
            if (ang_full > ANG_LIM)
            begin
                ang_next = CMD_W'(ANG_LIM);
            end
            else if (ang_full < -ANG_LIM)
            begin
                ang_next = CMD_W'(-ANG_LIM);
            end
            else
            begin
                ang_next = CMD_W'(ang_full);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_v_reg       <= 1'b0;
            d_v_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_v_reg       <= v_reg[NS-1];
            d_v_reg       <= m_v_reg;
            out_valid_reg <= d_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lin_reg     <= lin_next;
            ang_reg     <= ang_next;
            reached_reg <= reached_next;
        end
    end

    assign cmd.valid   = out_valid_reg;
    assign cmd.lin_cmd = lin_reg;
    assign cmd.ang_cmd = ang_reg;
    assign cmd.reached = reached_reg;
endmodule

@@ rtl/go_to_goal_p_controller.sv @@
// Go-to-goal proportional controller top level: config registers, front end, queue, back end.
// Throughput: one pose per cycle while the command output is not stalled.
// The CORDIC stages and the split gain multiply are pipelined.
// A stalled output holds the back end; the front end keeps taking poses until the queue fills.
// Reset (rst_n low, asynchronous): pipeline empty, goal_x = goal_y = 0, stop_tolerance = 41.
module go_to_goal_p_controller #(
    parameter int FRAC_BITS     = 12,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    gtg_pose_if.sink                      pose,
    gtg_cmd_if.source                     cmd,
    input  logic                          wr_en,
    input  logic [gtg_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [gtg_pkg::CFG_W-1:0]     wr_data
);
    import gtg_pkg::*;

    logic [CFG_W-1:0] goal_x_reg;
    logic [CFG_W-1:0] goal_y_reg;
    logic [CFG_W-1:0] tol_reg;

    logic       f_valid;
    pose_item_t f_item;
    logic       f_ready;
    logic       q_valid;
    pose_item_t q_item;
    logic       q_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_x_reg <= '0;
            goal_y_reg <= '0;
            tol_reg    <= TOL_RESET;
        end
        else if (wr_en)
        begin
            case (cfg_reg_t'(wr_index))
                REG_GOAL_X:   goal_x_reg <= wr_data;
                REG_GOAL_Y:   goal_y_reg <= wr_data;
                REG_STOP_TOL: tol_reg    <= wr_data;
                default:      ;
            endcase
        end
    end

    gtg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .goal_x     (goal_x_reg),
        .goal_y     (goal_y_reg),
        .pose       (pose),
        .item_valid (f_valid),
        .item       (f_item),
        .item_ready (f_ready)
    );

    gtg_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_item  (f_item),
        .wr_ready (f_ready),
        .rd_valid (q_valid),
        .rd_item  (q_item),
        .rd_ready (q_ready)
    );

    gtg_back #(
        .FRAC_BITS     (FRAC_BITS),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .stop_tolerance (tol_reg),
        .item_valid     (q_valid),
        .item           (q_item),
        .item_ready     (q_ready),
        .cmd            (cmd)
    );
endmodule

@@ rtl/gtg_checker.sv @@
// Port-level checks on the command channel, bound to the top level.
module gtg_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [gtg_pkg::CMD_W-1:0]        lin_cmd,
    input logic signed [gtg_pkg::CMD_W-1:0] ang_cmd,
    input logic                             reached
);
    import gtg_pkg::*;

    a_reached_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && reached |-> lin_cmd == '0 && ang_cmd == '0)
        else $error("reached with nonzero command");

    a_moving_speed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !reached |-> lin_cmd != '0)
        else $error("goal not reached but zero speed");

    a_speed_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !reached |-> lin_cmd <= CMD_W'(139264))
        else $error("speed above 1.5 times largest distance");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(lin_cmd) && $stable(ang_cmd)
            && $stable(reached))
        else $error("stalled transfer changed");
endmodule

bind go_to_goal_p_controller gtg_checker u_gtg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (cmd.valid),
    .out_ready (cmd.ready),
    .lin_cmd   (cmd.lin_cmd),
    .ang_cmd   (cmd.ang_cmd),
    .reached   (cmd.reached)
);

@@ test/go_to_goal_p_controller_test.sv @@
// Self-checking testbench for the go-to-goal controller: random poses, CORDIC-based predictor.
module go_to_goal_p_controller_test;
    import gtg_pkg::*;

    localparam int FRAC_BITS     = 12;
    localparam int CORDIC_STAGES = 16;
    localparam int SINK_HOLD     = 300;
    localparam int NEAR_SPAN     = 300;
    localparam int IDLE_PCT      = 28;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    localparam longint ATAN_STEP [16] = '{
        843314857, 497837829, 263043837, 133525159,
        67021687, 33543516, 16775851, 8388437,
        4194283, 2097149, 1048576, 524288,
        262144, 131072, 65536, 32768
    };

    typedef struct {
        logic [POS_W-1:0]       pos_x;
        logic [POS_W-1:0]       pos_y;
        logic signed [HD_W-1:0] heading;
    } pose_t;

    typedef struct {
        logic [CMD_W-1:0]        lin_cmd;
        logic signed [CMD_W-1:0] ang_cmd;
        logic                    reached;
    } cmd_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 wr_en;
    logic [CFG_IDX_W-1:0] wr_index;
    logic [CFG_W-1:0]     wr_data;
    logic                 sink_hold_req;

    logic [CFG_W-1:0] goal_x_q = '0;
    logic [CFG_W-1:0] goal_y_q = '0;
    logic [CFG_W-1:0] stop_tol_q = TOL_RESET;

    pose_t pose_queue [$];
    cmd_t  cmd_expect_q [$];
    pose_t next_pose;
    cmd_t  want;

    int items_sent = 0;
    int results_seen = 0;
    int errors = 0;
    int src_idle_pct = IDLE_PCT;
    int sink_idle_pct = IDLE_PCT;
    int hold_left;

    gtg_pose_if pose_ch ();
    gtg_cmd_if  cmd_ch ();

    go_to_goal_p_controller #(
        .FRAC_BITS     (FRAC_BITS),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .pose     (pose_ch),
        .cmd      (cmd_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic cmd_t steer_command(input pose_t p);
        cmd_t c;
        longint dx, dy, x, y, z, t, xs, ys, bearing, lin, ang, lim, pif, rnd;
        longint unsigned distance;
        dx = longint'(goal_x_q) - longint'(p.pos_x);
        dy = longint'(goal_y_q) - longint'(p.pos_y);
        x = dx <<< GUARD;
        y = dy <<< GUARD;
        z = 0;
        distance = 0;
        if (dx != 0 || dy != 0)
        begin
            if (x < 0)
            begin
                t = x;
                if (y >= 0)
                begin
                    x = y;
                    y = -t;
                    z = longint'(HALF_PI_Q30);
                end
                else
                begin
                    x = -y;
                    y = t;
                    z = -longint'(HALF_PI_Q30);
                end
            end
            for (int i = 0; i < CORDIC_STAGES; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (y > 0)
                begin
                    x = x + ys;
                    y = y - xs;
                    z = z + ATAN_STEP[i];
                end
                else
                begin
                    x = x - ys;
                    y = y + xs;
                    z = z - ATAN_STEP[i];
                end
            end
            if (x < 0)
                x = 0;
            distance = ($unsigned(x) * INV_GAIN + (64'd1 << (29 + GUARD))) >> (30 + GUARD);
        end
        if (distance <= stop_tol_q)
        begin
            c.lin_cmd = '0;
            c.ang_cmd = '0;
            c.reached = 1'b1;
            return c;
        end
        rnd = longint'(1) <<< (29 - FRAC_BITS);
        pif = (longint'(PI_Q30) + rnd) >>> (30 - FRAC_BITS);
        bearing = (z + rnd) >>> (30 - FRAC_BITS);
        if (bearing > pif)
            bearing = pif;
        if (bearing < -pif)
            bearing = -pif;
        lin = (3 * longint'(distance) + 1) >>> 1;
        if (lin > longint'(LIN_MAX))
            lin = longint'(LIN_MAX);
        ang = 4 * (bearing - longint'(p.heading));
        lim = 8 * pif;
        if (lim > ANG_LIM18)
            lim = ANG_LIM18;
        if (ang > lim)
            ang = lim;
        if (ang < -lim)
            ang = -lim;
        c.lin_cmd = lin[CMD_W-1:0];
        c.ang_cmd = ang[CMD_W-1:0];
        c.reached = 1'b0;
        return c;
    endfunction

    // pose driver
    always @(posedge clk)
    begin
        if (!rst_n)
            pose_ch.valid <= 1'b0;
        else if (!pose_ch.valid || pose_ch.ready)
        begin
            if (pose_queue.size() > 0 && $urandom_range(0, 99) >= src_idle_pct)
            begin
                next_pose = pose_queue.pop_front();
                pose_ch.valid   <= 1'b1;
                pose_ch.pos_x   <= next_pose.pos_x;
                pose_ch.pos_y   <= next_pose.pos_y;
                pose_ch.heading <= next_pose.heading;
            end
            else
                pose_ch.valid <= 1'b0;
        end
    end

    // command receiver, with a long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            cmd_ch.ready <= 1'b0;
            hold_left <= 0;
        end
        else if (sink_hold_req)
        begin
            hold_left <= SINK_HOLD;
            cmd_ch.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            cmd_ch.ready <= 1'b0;
        end
        else
            cmd_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // check command transfers, then record pose transfers
    always @(posedge clk)
    begin
        if (rst_n && cmd_ch.valid && cmd_ch.ready)
        begin
            results_seen++;
            if (cmd_expect_q.size() == 0)
            begin
                errors++;
                $display("%0t unexpected command: lin %0d ang %0d reached %0b", $time,
                         cmd_ch.lin_cmd, cmd_ch.ang_cmd, cmd_ch.reached);
            end
            else
            begin
                want = cmd_expect_q.pop_front();
                if (cmd_ch.lin_cmd !== want.lin_cmd)
                begin
                    errors++;
                    $display("%0t lin_cmd: expected %0d got %0d", $time,
                             want.lin_cmd, cmd_ch.lin_cmd);
                end
                if (cmd_ch.ang_cmd !== want.ang_cmd)
                begin
                    errors++;
                    $display("%0t ang_cmd: expected %0d got %0d", $time,
                             want.ang_cmd, cmd_ch.ang_cmd);
                end
                if (cmd_ch.reached !== want.reached)
                begin
                    errors++;
                    $display("%0t reached: expected %0b got %0b", $time,
                             want.reached, cmd_ch.reached);
                end
            end
        end
        if (rst_n && pose_ch.valid && pose_ch.ready)
            cmd_expect_q.push_back(steer_command('{pose_ch.pos_x, pose_ch.pos_y,
                                                   pose_ch.heading}));
    end

    task automatic add_pose(input logic [POS_W-1:0] px, input logic [POS_W-1:0] py,
                            input int hd);
        pose_t p;
        p.pos_x = px;
        p.pos_y = py;
        p.heading = hd[HD_W-1:0];
        pose_queue.push_back(p);
        items_sent++;
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        case (idx)
            REG_GOAL_X:   goal_x_q = val;
            REG_GOAL_Y:   goal_y_q = val;
            REG_STOP_TOL: stop_tol_q = val;
            default:      ;
        endcase
    endtask

    task automatic load_goal(input logic [CFG_W-1:0] gx, input logic [CFG_W-1:0] gy,
                             input logic [CFG_W-1:0] tol, input bit poke_spare);
        cfg_write(REG_GOAL_X, gx);
        cfg_write(REG_GOAL_Y, gy);
        cfg_write(REG_STOP_TOL, tol);
        if (poke_spare)
            cfg_write(REG_SPARE, 16'hFFFF);
        @(posedge clk);
        wr_en <= 1'b0;
    endtask

    task automatic drain();
        while (results_seen < items_sent)
            @(posedge clk);
    endtask

    function automatic logic [POS_W-1:0] near(input logic [POS_W-1:0] center);
        int v;
        v = int'(center) + int'($urandom_range(0, 2 * NEAR_SPAN)) - NEAR_SPAN;
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return v[POS_W-1:0];
    endfunction

    task automatic add_random_pose();
        int kind;
        kind = $urandom_range(0, 99);
        if (kind < 55)
            add_pose(POS_W'($urandom_range(0, 65535)), POS_W'($urandom_range(0, 65535)),
                     int'($urandom_range(0, 25736)) - 12868);
        else if (kind < 85)
            add_pose(near(goal_x_q), near(goal_y_q), int'($urandom_range(0, 25736)) - 12868);
        else if (kind < 92)
            add_pose($urandom_range(0, 1) ? 16'hFFFF : 16'h0000,
                     $urandom_range(0, 1) ? 16'hFFFF : 16'h0000,
                     int'($urandom_range(0, 32767)) - 16384);
        else
            add_pose(POS_W'($urandom_range(0, 65535)), POS_W'($urandom_range(0, 65535)),
                     int'($urandom_range(0, 32767)) - 16384);
    endtask

    initial
    begin
        rst_n = 1'b0;
        wr_en = 1'b0;
        wr_index = '0;
        wr_data = '0;
        sink_hold_req = 1'b0;
        pose_ch.valid = 1'b0;
        pose_ch.pos_x = '0;
        pose_ch.pos_y = '0;
        pose_ch.heading = '0;
        cmd_ch.ready = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset goal at origin, tolerance 41
        add_pose(16'h0000, 16'h0000, 0);
        add_pose(16'd29, 16'd29, 0);
        add_pose(16'd41, 16'h0000, 0);
        add_pose(16'd42, 16'h0000, 0);
        add_pose(16'hFFFF, 16'hFFFF, -16384);
        add_pose(16'hFFFF, 16'h0000, 16383);
        add_pose(16'h0000, 16'hFFFF, 12868);
        add_pose(16'd1000, 16'h0000, -12868);
        add_pose(16'h0000, 16'd1000, 0);
        drain();

        // zero tolerance; the write to the spare index must not touch it
        load_goal(16'h8000, 16'h8000, 16'h0000, 1'b1);
        add_pose(16'h8000, 16'h8000, 0);
        add_pose(16'h8001, 16'h8000, 0);
        add_pose(16'h7000, 16'h8000, 0);
        add_pose(16'h9000, 16'h8000, 0);
        add_pose(16'h8000, 16'h7000, 0);
        add_pose(16'h8000, 16'h9000, 0);
        add_pose(16'h7000, 16'h7000, 100);
        add_pose(16'h9000, 16'h9000, -100);
        add_pose(16'h9000, 16'h7000, 12868);
        add_pose(16'h7000, 16'h9000, -12868);
        add_pose(16'h0000, 16'h0000, -16384);
        add_pose(16'hFFFF, 16'h8000, -16384);
        add_pose(16'hFFFF, 16'h8000, 16383);
        add_pose(16'hFFFF, 16'h8001, 16383);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            src_idle_pct  = (ph == 1) ? 0 : IDLE_PCT;
            sink_idle_pct = (ph == 1) ? 0 : IDLE_PCT;
            case (ph)
                2:       load_goal(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
                3:       load_goal(16'h0000, 16'hFFFF, TOL_RESET, 1'b0);
                4:       load_goal(CFG_W'($urandom_range(0, 65535)),
                                   CFG_W'($urandom_range(0, 65535)),
                                   16'h0000, 1'b0);
                5:       load_goal(CFG_W'($urandom_range(0, 65535)),
                                   CFG_W'($urandom_range(0, 65535)),
                                   CFG_W'($urandom_range(0, 2000)), 1'b0);
                default: load_goal(CFG_W'($urandom_range(0, 65535)),
                                   CFG_W'($urandom_range(0, 65535)),
                                   CFG_W'($urandom_range(0, 400)), 1'b0);
            endcase
            repeat (105) add_random_pose();
            if (ph == 3)
            begin
                // receiver holds off while poses keep coming
                @(posedge clk);
                sink_hold_req <= 1'b1;
                @(posedge clk);
                sink_hold_req <= 1'b0;
            end
            drain();
        end

        repeat (40) @(posedge clk);
        if (cmd_expect_q.size() != 0)
        begin
            errors++;
            $display("%0t %0d commands never arrived", $time, cmd_expect_q.size());
        end
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #400000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
